FILE: sv/kgsq_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the k-mer graph successor query block
// no dependencies; imported by kgsq_ctrl, kgsq_dpath and the top level

package kgsq_pkg;

  // default longest k-mer, in nucleotides
  localparam int unsigned KMaxDef = 12;
  // shortest usable k-mer
  localparam int unsigned KMin    = 2;

  // stream and configuration widths
  localparam int unsigned KmerW    = 24;
  localparam int unsigned SDataW   = 24;
  localparam int unsigned MDataW   = 16;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 4;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_KLEN = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CFG_MODE = CfgIdxW'(1);

  // item kinds carried on tuser
  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_RANGE    = 2'd1,
    ST_NONCANON = 2'd2,
    ST_ORDER    = 2'd3
  } status_e;

  // controller to datapath
  typedef struct packed {
    logic       clr_step;
    logic       accept;
    logic       issue;
    logic [2:0] slot;
    logic       ins_wr;
    logic       load_out;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic qry_oor;
    logic is_query;
  } dp_sts_t;

endpackage

FILE: sv/kgsq_ctrl.sv
`timescale 1ns / 1ps
// sequencer for the k-mer graph successor query block
// depends on kgsq_pkg; drives kgsq_dpath through ctrl_cmd_t

module kgsq_ctrl import kgsq_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      s_tvalid_i,
  output logic      s_tready_o,
  input  logic      m_tready_i,
  output logic      m_tvalid_o,
  input  dp_sts_t   sts_i,
  output ctrl_cmd_t cmd_o
);

  localparam logic [2:0] S_CLEAR  = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_ISSUE  = 3'd2;
  localparam logic [2:0] S_DRAIN  = 3'd3;
  localparam logic [2:0] S_INS_B  = 3'd4;
  localparam logic [2:0] S_INS_RD = 3'd5;
  localparam logic [2:0] S_INS_WR = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  // lookup pipeline depth behind the issue stage
  localparam logic [2:0] DrainLast = 3'd2;
  localparam logic [2:0] SlotLast  = 3'd7;

  logic [2:0] state_q, state_d;
  logic [2:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (s_tvalid_i) begin
          cmd_o.accept = 1'b1;
          cnt_d        = '0;
          state_d      = S_ISSUE;
        end
      end
      S_ISSUE: begin
        cmd_o.slot = cnt_q;
        if (!sts_i.is_query) begin
          cmd_o.issue = 1'b1;
          state_d     = S_INS_B;
        end else if (sts_i.qry_oor) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.issue = 1'b1;
          if (cnt_q == SlotLast) begin
            cnt_d   = '0;
            state_d = S_DRAIN;
          end else begin
            cnt_d = cnt_q + 3'd1;
          end
        end
      end
      S_DRAIN: begin
        if (cnt_q == DrainLast) begin
          state_d = S_FINISH;
        end else begin
          cnt_d = cnt_q + 3'd1;
        end
      end
      S_INS_B: begin
        state_d = S_INS_RD;
      end
      S_INS_RD: begin
        state_d = S_INS_WR;
      end
      S_INS_WR: begin
        cmd_o.ins_wr = 1'b1;
        state_d      = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || m_tready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.load_out ? 1'b1 : (out_valid_q & ~m_tready_i);
  assign s_tready_o  = (state_q == S_IDLE);
  assign m_tvalid_o  = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: sv/kgsq_dpath.sv
`timescale 1ns / 1ps
// datapath: config registers, canonical-form lookup pipeline and presence bitmap
// depends on kgsq_pkg; commanded by kgsq_ctrl

module kgsq_dpath import kgsq_pkg::*; #(
  parameter int unsigned K_MAX = KMaxDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic [KmerW-1:0]    kmer_i,
  input  logic                action_i,
  input  ctrl_cmd_t           cmd_i,
  output dp_sts_t             sts_o,
  output logic [7:0]          mask_o,
  output logic                any_o,
  output status_e             status_o
);

  localparam int unsigned VW     = 2 * K_MAX;
  localparam int unsigned MapAw  = VW - 1;
  localparam int unsigned OffW   = (MapAw > 5) ? 5 : MapAw - 1;
  localparam int unsigned RowW   = 1 << OffW;
  localparam int unsigned RowAw  = MapAw - OffW;
  localparam int unsigned Depth  = 1 << RowAw;
  localparam int unsigned KW     = $clog2(K_MAX + 1);
  localparam int unsigned CmpW   = 6;
  localparam logic [KW-1:0] KMaxC = KW'(K_MAX);
  localparam logic [KW-1:0] KMinC = KW'(KMin);
  localparam logic [KW-1:0] KRst  = KW'((KMaxDef < K_MAX) ? KMaxDef : K_MAX);

  // configuration
  logic [KW-1:0]   k_q;
  logic            mode_q;
  logic [KW-1:0]   k_wr;
  logic [CmpW-1:0] cfg_wide;

  // item
  logic             action_q;
  logic [KmerW-1:0] x_q;
  logic [VW-1:0]    xv;

  // stage a
  logic [1:0]    lt, letter, cx;
  logic [VW-1:0] nx, pv, cand, rf, rc;
  logic [2:0]    pos;
  logic [KW:0]   sh_rc, sh_pv, sh_lim;
  logic [VW-1:0] v_q, rc_q;
  logic [2:0]    a_pos_q;
  logic          a_valid_q;

  // stage b
  logic [VW-1:0]    canon, lim;
  logic             inmap, ins_oor, qry_oor;
  status_e          ins_st;
  logic [MapAw-1:0] addr_q;
  logic             b_ok_q, b_valid_q;
  logic [2:0]       b_pos_q;
  status_e          ins_status_q;
  logic [MapAw-1:0] last_q;

  // stage c and bitmap
  logic [RowW-1:0]  mem_q [Depth];
  logic [RowW-1:0]  rdata_q, mem_wdata;
  logic [RowAw-1:0] clr_row_q, mem_row;
  logic             mem_we, ins_we;
  logic [OffW-1:0]  c_off_q;
  logic             c_ok_q, c_valid_q;
  logic [2:0]       c_pos_q;

  // stage d and result
  logic [7:0] mask_q;
  logic       hit;
  logic [7:0] out_mask_q;
  logic       out_any_q;
  status_e    out_status_q;

  // config: length is clamped into the supported range when written
  always_comb begin
    cfg_wide = CmpW'(cfg_data_i);
    if (cfg_wide < CmpW'(KMin)) begin
      k_wr = KMinC;
    end else if (cfg_wide > CmpW'(K_MAX)) begin
      k_wr = KMaxC;
    end else begin
      k_wr = KW'(cfg_data_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q    <= KRst;
      mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_KLEN: k_q    <= k_wr;
        CFG_MODE: mode_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      action_q <= action_i;
      x_q      <= kmer_i;
    end
  end

  assign xv = VW'(x_q);

  // range checks on the raw 24-bit word
  always_comb begin
    ins_oor = 1'b0;
    qry_oor = 1'b0;
    for (int b = 0; b < KmerW; b++) begin
      if (CmpW'(b) >= CmpW'({k_q, 1'b0})) ins_oor = ins_oor | x_q[b];
      if (CmpW'(b) >= CmpW'({k_q - KW'(1), 1'b0})) qry_oor = qry_oor | x_q[b];
    end
  end

  // stage a: candidate k-mer and its reverse complement
  always_comb begin
    lt     = cmd_i.slot[1:0];
    cx     = mode_q ? 2'b10 : 2'b11;
    letter = (mode_q && lt[1]) ? (lt ^ 2'b01) : lt;
    pos    = cmd_i.slot[2] ? (3'd3 - {1'b0, letter}) : (3'd7 - {1'b0, letter});
    sh_rc  = {KMaxC - k_q, 1'b0};
    sh_pv  = {k_q - KW'(1), 1'b0};
    nx     = {xv[VW-3:0], lt};
    pv     = (VW'(lt) << sh_pv) | xv;
    if (action_q == ACT_INSERT) begin
      cand = xv;
    end else if (cmd_i.slot[2]) begin
      cand = pv;
    end else begin
      cand = nx;
    end
    // full-width digit reversal, then drop the unused low digits
    for (int j = 0; j < K_MAX; j++) begin
      rf[2*(K_MAX-1-j) +: 2] = cand[2*j +: 2] ^ cx;
    end
    rc = rf >> sh_rc;
  end

  always_ff @(posedge clk_i) begin
    v_q     <= cand;
    rc_q    <= rc;
    a_pos_q <= pos;
  end

  // stage b: canonical form, bitmap bound and insert checks
  always_comb begin
    sh_lim = {k_q, 1'b0} - (KW+1)'(1);
    lim    = VW'(1) << sh_lim;
    canon  = (v_q < rc_q) ? v_q : rc_q;
    inmap  = (canon < lim);
    if (ins_oor) begin
      ins_st = ST_RANGE;
    end else if (v_q > rc_q) begin
      ins_st = ST_NONCANON;
    end else if (v_q >= lim) begin
      ins_st = ST_RANGE;
    end else if (v_q < VW'(last_q)) begin
      ins_st = ST_ORDER;
    end else begin
      ins_st = ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q       <= canon[MapAw-1:0];
    b_ok_q       <= inmap;
    b_pos_q      <= a_pos_q;
    ins_status_q <= ins_st;
  end

  // bitmap: one port, row-wide, clear sweep after reset
  assign ins_we    = cmd_i.ins_wr && (ins_status_q == ST_OK);
  assign mem_we    = cmd_i.clr_step | ins_we;
  assign mem_row   = cmd_i.clr_step ? clr_row_q : addr_q[MapAw-1 -: RowAw];
  assign mem_wdata = cmd_i.clr_step ? '0 : (rdata_q | (RowW'(1) << c_off_q));

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_row] <= mem_wdata;
    end else begin
      rdata_q <= mem_q[mem_row];
    end
  end

  always_ff @(posedge clk_i) begin
    c_off_q <= addr_q[OffW-1:0];
    c_ok_q  <= b_ok_q;
    c_pos_q <= b_pos_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      clr_row_q <= '0;
      last_q    <= '0;
    end else begin
      a_valid_q <= cmd_i.issue;
      b_valid_q <= a_valid_q;
      c_valid_q <= b_valid_q;
      if (cmd_i.clr_step) begin
        clr_row_q <= clr_row_q + RowAw'(1);
      end
      if (ins_we) begin
        last_q <= addr_q;
      end
    end
  end

  // stage d: collect hits into the neighbor mask
  assign hit = c_valid_q && (action_q == ACT_QUERY) && c_ok_q && rdata_q[c_off_q];

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mask_q <= '0;
    end else if (hit) begin
      mask_q[c_pos_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_mask_q <= mask_q;
      out_any_q  <= |mask_q;
      if (action_q == ACT_QUERY) begin
        out_status_q <= qry_oor ? ST_RANGE : ST_OK;
      end else begin
        out_status_q <= ins_status_q;
      end
    end
  end

  assign sts_o.clr_last = &clr_row_q;
  assign sts_o.qry_oor  = qry_oor;
  assign sts_o.is_query = (action_q == ACT_QUERY);
  assign mask_o         = out_mask_q;
  assign any_o          = out_any_q;
  assign status_o       = out_status_q;

endmodule

FILE: sv/kmer_graph_successor_query.sv
`timescale 1ns / 1ps
// top level of the k-mer graph successor query block
// depends on kgsq_pkg, kgsq_ctrl and kgsq_dpath
//
// channel   direction  handshake              payload
// s_        in         s_tvalid_i/s_tready_o  tdata kmer, tuser action
// m_        out        m_tvalid_o/m_tready_i  tdata mask, any flag, status
// cfg_      in         cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// a query makes eight bitmap reads through the single-port row memory, plus fill, before its result
// is loaded; the next input is taken only after that
// an insert result is loaded after check, one row read, one row write
// after reset the bitmap is swept clear one 32-bit row per cycle,
// 2^(2*K_MAX-6) rows (262144 for K_MAX of 12); no input is taken meanwhile
// a finished result waits in the output register while the next item is taken

module kmer_graph_successor_query import kgsq_pkg::*; #(
  parameter int unsigned K_MAX = KMaxDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  // input stream
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  input  logic [SDataW-1:0]   s_tdata_i,   // [23:0] kmer
  input  logic                s_tuser_i,   // [0] action: insert or query
  // result stream
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic [MDataW-1:0]   m_tdata_o,   // [7:0] successor_mask, [8] any_present,
                                           // [10:9] status, [15:11] zero
  // configuration writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  ctrl_cmd_t  cmd;
  dp_sts_t    sts;
  logic [7:0] mask;
  logic       any;
  status_e    status;

  // registers are always writable; the user must issue writes only while idle, the block does not enforce it
  assign cfg_ready_o = 1'b1;

  kgsq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .m_tready_i (m_tready_i),
    .m_tvalid_o (m_tvalid_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  kgsq_dpath #(
    .K_MAX (K_MAX)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .kmer_i      (s_tdata_i[KmerW-1:0]),
    .action_i    (s_tuser_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .mask_o      (mask),
    .any_o       (any),
    .status_o    (status)
  );

  // result fields packed from the low bit up
  assign m_tdata_o = MDataW'({status, any, mask});

endmodule

FILE: tb/tb_kmer_graph_successor_query.sv
`timescale 1ns / 1ps
// self-checking testbench for kmer_graph_successor_query: directed table, then random phases
// depends on kgsq_pkg and the block rtl; keeps its own bitmap, order and register state

module tb_kmer_graph_successor_query;
  import kgsq_pkg::*;

  localparam int unsigned KLong      = KMaxDef;
  localparam int unsigned CycleLimit = 1500000;  // clearing sweep plus every item, many times over
  localparam int unsigned ReportMax  = 10;
  localparam int unsigned RecentMax  = 32;
  localparam int unsigned TailCycles = 40;
  localparam int unsigned IdlePct    = 24;
  localparam int unsigned NumPhases  = 9;
  localparam int unsigned PhaseItems = 195;
  localparam int unsigned QuietPhase = 4;        // no idling on either side in this phase

  // register index the block does not decode
  localparam logic [CfgIdxW-1:0] CfgUnused = CfgIdxW'(15);

  // length and coding per random phase, short k-mers first so the insert order can climb
  localparam int unsigned PhaseK    [NumPhases] = '{2, 3, 4, 5, 6, 8, 10, 12, 12};
  localparam int unsigned PhaseMode [NumPhases] = '{0, 1, 0, 1, 0, 1, 0, 1, 0};

  typedef struct packed {
    logic [7:0] mask;
    logic       any;
    status_e    status;
  } answer_t;

  typedef enum logic [1:0] { ROW_INSERT, ROW_QUERY, ROW_CFG } row_kind_e;

  typedef struct {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] index;
    logic [KmerW-1:0]   value;
    bit                 typed;
    answer_t            answer;
  } dir_row_t;

  // clock, reset and every block input start at known values
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                s_tvalid_i  = 1'b0;
  logic                s_tready_o;
  logic [SDataW-1:0]   s_tdata_i   = '0;   // [23:0] kmer
  logic                s_tuser_i   = 1'b0; // [0] action
  logic                m_tvalid_o;
  logic                m_tready_i  = 1'b0;
  logic [MDataW-1:0]   m_tdata_o;          // [7:0] mask, [8] any, [10:9] status
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i  = '0;

  // mirror of the block state
  bit          kmer_seen [int unsigned];
  int unsigned last_kept = 0;
  logic [3:0]  klen_reg  = 4'(KLong);
  logic        enc_mode  = 1'b0;
  int unsigned recent_kmers [$];

  answer_t     pending_answers [$];
  int unsigned errors   = 0;
  int unsigned cycles   = 0;
  int unsigned idle_pct = IdlePct;
  int unsigned n_status [4];
  int unsigned n_hits   = 0;

  always #5 clk_i = ~clk_i;

  kmer_graph_successor_query #(
    .K_MAX(KLong)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .s_tuser_i  (s_tuser_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  // length register clamps to 2..K_MAX
  function automatic int unsigned eff_k();
    if (klen_reg < KMin) return KMin;
    if (klen_reg > KLong) return KLong;
    return int'(klen_reg);
  endfunction

  // reverse complement of an n-letter word under the current coding
  function automatic int unsigned rev_comp(int unsigned x, int unsigned n);
    int unsigned r;
    r = 0;
    for (int unsigned j = 0; j < n; j++)
      r = (r << 2) | (((x >> (2 * j)) & 3) ^ (enc_mode ? 2 : 3));
    return r;
  endfunction

  function automatic int unsigned canon(int unsigned x, int unsigned n);
    int unsigned r;
    r = rev_comp(x, n);
    return (x < r) ? x : r;
  endfunction

  // words past the bitmap can never be stored and read as absent
  function automatic bit bitmap_has(int unsigned idx, int unsigned k);
    return (idx < (32'd1 << (2 * k - 1))) && kmer_seen.exists(idx);
  endfunction

  // mask bits follow letter order, so G and T swap in the second coding
  function automatic int unsigned letter_pos(int unsigned code);
    return (enc_mode && (code & 2)) ? (code ^ 1) : code;
  endfunction

  // result of one transaction, updating the mirrored bitmap and order state
  function automatic answer_t answer_item(logic act, int unsigned x);
    answer_t     a;
    int unsigned k, n, span, nx, pv, pos;
    a = '{mask: 8'h00, any: 1'b0, status: ST_OK};
    k = eff_k();
    span = 32'd1 << (2 * k - 1);
    if (act == ACT_INSERT) begin
      // first failing check wins, state untouched on any failure
      if ((x >> (2 * k)) != 0) a.status = ST_RANGE;
      else if (x > rev_comp(x, k)) a.status = ST_NONCANON;
      else if (x >= span) a.status = ST_RANGE;
      else if (x < last_kept) a.status = ST_ORDER;
      else begin
        kmer_seen[x] = 1'b1;
        last_kept = x;
        recent_kmers = {recent_kmers, x};
        if (recent_kmers.size() > RecentMax) void'(recent_kmers.pop_front());
      end
    end else begin
      n = k - 1;
      if ((x >> (2 * n)) != 0) a.status = ST_RANGE;
      else begin
        for (int unsigned c = 0; c < 4; c++) begin
          pos = letter_pos(c);
          nx = (x << 2) | c;
          pv = (c << (2 * n)) | x;
          if (bitmap_has(canon(nx, k), k)) a.mask[7 - pos] = 1'b1;
          if (bitmap_has(canon(pv, k), k)) a.mask[3 - pos] = 1'b1;
        end
      end
    end
    a.any = |a.mask;
    n_status[a.status]++;
    if (a.any) n_hits++;
    return a;
  endfunction

  function automatic dir_row_t mk_row(row_kind_e kind, logic [CfgIdxW-1:0] index,
                                      int unsigned value, bit typed = 1'b0,
                                      status_e status = ST_OK);
    dir_row_t r;
    r.kind   = kind;
    r.index  = index;
    r.value  = KmerW'(value);
    r.typed  = typed;
    r.answer = '{mask: 8'h00, any: 1'b0, status: status};
    return r;
  endfunction

  // mostly ascending canonical inserts and queries around stored k-mers, some noise
  function automatic void pick_item(output logic act, output int unsigned x);
    int unsigned k, span, qmask, y, pick;
    k = eff_k();
    span = 32'd1 << (2 * k - 1);
    qmask = (32'd1 << (2 * (k - 1))) - 1;
    pick = $urandom_range(99);
    act = ACT_QUERY;
    x = 0;
    if (pick < 40) begin
      act = ACT_INSERT;
      for (int t = 0; t < 8; t++) begin
        x = last_kept + $urandom_range(span / 256 + 1);
        if (x < span && x <= rev_comp(x, k)) break;
      end
    end else if (pick < 75 && recent_kmers.size() != 0) begin
      // prefix or suffix of a stored k-mer or of its reverse complement
      y = recent_kmers[$urandom_range(recent_kmers.size() - 1)];
      if ($urandom_range(1)) y = rev_comp(y, k);
      x = $urandom_range(1) ? ((y >> 2) & qmask) : (y & qmask);
    end else if (pick < 90) begin
      x = $urandom_range(qmask);
    end else begin
      act = logic'($urandom_range(1));
      x = $urandom_range(1) ? $urandom_range(32'hFFFFFF) : $urandom_range(qmask * 4 + 3);
    end
  endfunction

  // one input transaction; valid stays high afterwards unless the next call idles
  task automatic send_item(logic act, int unsigned x, bit typed, answer_t typed_answer);
    answer_t a;
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tuser_i  <= act;
    s_tdata_i  <= KmerW'(x);
    do @(posedge clk_i); while (!s_tready_o);
    a = answer_item(act, x);
    if (typed) a = typed_answer;
    pending_answers = {pending_answers, a};
  endtask

  task automatic wait_drain();
    s_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (pending_answers.size() != 0);
  endtask

  // register write, only issued with nothing in flight
  task automatic write_cfg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_KLEN) klen_reg = data;
    else if (idx == CFG_MODE) enc_mode = data[0];
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // result side: compare each transaction with the oldest expectation, stall at random
  always @(posedge clk_i) begin : result_check
    answer_t got, want;
    got = '{mask: m_tdata_o[7:0], any: m_tdata_o[8], status: status_e'(m_tdata_o[10:9])};
    if (m_tvalid_o && m_tready_i) begin
      if (pending_answers.size() == 0) begin
        errors++;
        if (errors <= ReportMax)
          $display("cycle %0d: result with nothing pending: mask %02h any %0b status %0d",
                   cycles, got.mask, got.any, got.status);
      end else begin
        want = pending_answers.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= ReportMax)
            $display({"cycle %0d: expected mask %02h any %0b status %0d, ",
                      "got mask %02h any %0b status %0d"},
                     cycles, want.mask, want.any, want.status, got.mask, got.any, got.status);
        end
      end
    end
    m_tready_i <= ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk_i) begin : watchdog
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_answers.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t    rows [$];
    logic        act;
    int unsigned x;
    answer_t     blank;
    blank = '{mask: 8'h00, any: 1'b0, status: ST_OK};

    // k of 12 and the first coding after reset; typed rows read straight off the rules
    rows = {
      mk_row(ROW_QUERY,  '0, 24'h000000, 1'b1, ST_OK),        // empty bitmap
      mk_row(ROW_QUERY,  '0, 24'h3FFFFF, 1'b1, ST_OK),        // largest valid 11-mer
      mk_row(ROW_QUERY,  '0, 24'h400000, 1'b1, ST_RANGE),     // first word past 4^(k-1)
      mk_row(ROW_QUERY,  '0, 24'hFFFFFF, 1'b1, ST_RANGE),
      mk_row(ROW_INSERT, '0, 24'hFFFFFF, 1'b1, ST_NONCANON),  // all T, complement all A
      mk_row(ROW_INSERT, '0, 24'h800000, 1'b1, ST_RANGE),     // canonical but past the bitmap
      mk_row(ROW_INSERT, '0, 24'h000000, 1'b1, ST_OK),
      mk_row(ROW_INSERT, '0, 24'h000001, 1'b1, ST_OK),
      mk_row(ROW_INSERT, '0, 24'h000000, 1'b1, ST_ORDER),     // below the last insert
      mk_row(ROW_INSERT, '0, 24'h000001, 1'b1, ST_OK),        // equal to the last insert
      mk_row(ROW_QUERY,  '0, 24'h000000),
      mk_row(ROW_CFG,    CFG_MODE, 1),
      mk_row(ROW_QUERY,  '0, 24'h000000),
      mk_row(ROW_INSERT, '0, 24'hFFFFFF, 1'b1, ST_NONCANON),
      mk_row(ROW_CFG,    CFG_KLEN, 0),                        // below 2, acts as 2
      mk_row(ROW_INSERT, '0, 24'h000010, 1'b1, ST_RANGE),     // not below 4^k
      mk_row(ROW_QUERY,  '0, 24'h000004, 1'b1, ST_RANGE),
      mk_row(ROW_QUERY,  '0, 24'h000003),
      mk_row(ROW_INSERT, '0, 24'h000002, 1'b1, ST_OK),        // its own reverse complement
      mk_row(ROW_CFG,    CFG_KLEN, 15),                       // above K_MAX, acts as K_MAX
      mk_row(ROW_QUERY,  '0, 24'h3FFFFF),
      mk_row(ROW_CFG,    CfgUnused, 15),                      // ignored by the block
      mk_row(ROW_CFG,    CFG_KLEN, 1),
      mk_row(ROW_QUERY,  '0, 24'h000001),
      mk_row(ROW_INSERT, '0, 24'h000003)
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // the first transaction waits out the bitmap clearing sweep
    foreach (rows[i]) begin
      case (rows[i].kind)
        ROW_CFG: begin
          wait_drain();
          write_cfg(rows[i].index, CfgDataW'(rows[i].value));
        end
        ROW_INSERT: send_item(ACT_INSERT, rows[i].value, rows[i].typed, rows[i].answer);
        default:    send_item(ACT_QUERY, rows[i].value, rows[i].typed, rows[i].answer);
      endcase
    end

    for (int p = 0; p < NumPhases; p++) begin
      wait_drain();
      write_cfg(CFG_KLEN, CfgDataW'(PhaseK[p]));
      write_cfg(CFG_MODE, CfgDataW'(PhaseMode[p]));
      idle_pct = (p == QuietPhase) ? 0 : IdlePct;
      for (int i = 0; i < PhaseItems; i++) begin
        // now and then hold off until every result is back
        if ($urandom_range(99) == 0) wait_drain();
        pick_item(act, x);
        send_item(act, x, 1'b0, blank);
      end
    end

    wait_drain();
    repeat (TailCycles) @(posedge clk_i);

    $display("run: %0d inserts/queries ok, %0d out of range, %0d not canonical, %0d out of order",
             n_status[ST_OK], n_status[ST_RANGE], n_status[ST_NONCANON], n_status[ST_ORDER]);
    $display("run: %0d queries found neighbors, %0d k-mers stored, %0d mismatches",
             n_hits, kmer_seen.num(), errors);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: kmer_graph_successor_query.f
sv/kgsq_pkg.sv
sv/kgsq_ctrl.sv
sv/kgsq_dpath.sv
sv/kmer_graph_successor_query.sv
tb/tb_kmer_graph_successor_query.sv
